/* src/cfdl_pkg.sv */
// cfdl_pkg: shared codes and fixed field widths for the cubic fractional delay line.
// No dependencies.
package cfdl_pkg;

  // Fixed widths of the configuration word and the delay field
  localparam int CFG_W     = 16;
  localparam int DELAY_W   = 27;
  // Line length after reset, before clamping to the store depth
  localparam int LEN_RESET = 32768;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

endpackage

/* src/cfdl_fifo.sv */
// cfdl_fifo: small first-in first-out queue between the front and back parts.
// No dependencies.
module cfdl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full  = (count == (PW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW + 1)'(1);
        2'b01:   count <= count - (PW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/cfdl_front.sv */
// cfdl_front: accepts transactions, holds line length and write pointer, clamps the
// delay and works out the four tap addresses. Depends on cfdl_pkg.
module cfdl_front import cfdl_pkg::*; #(
  parameter int MAX_DEPTH   = 32768,
  parameter int FRAC_BITS   = 12,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = $clog2(MAX_DEPTH),
  localparam int EW = 1 + SAMPLE_BITS + FRAC_BITS + 4 * AW + 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [DELAY_W-1:0]     delay_amount,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic                   q_push,
  output logic [EW-1:0]          q_wdata,
  input  logic                   q_full
);

  localparam int LW      = AW + 1;
  localparam int DW      = LW + FRAC_BITS;
  localparam int PW      = (DW > DELAY_W) ? DW : DELAY_W;
  localparam int QW      = DW + 1;
  localparam int LEN_RST = (LEN_RESET > MAX_DEPTH) ? MAX_DEPTH : LEN_RESET;

  typedef struct packed {
    cmd_t                       cmd;
    logic [SAMPLE_BITS-1:0]     data;
    logic [FRAC_BITS-1:0]       frac;
    logic [3:0][AW-1:0]         idx;
    logic [3:0]                 vld;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_POS  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state, state_next;

  logic [LW-1:0]          len;
  logic [AW-1:0]          wp;
  logic                   wrapped;
  cmd_t                   cur_cmd;
  logic [SAMPLE_BITS-1:0] cur_data;
  logic [DW-1:0]          dly;
  logic [AW-1:0]          centre;
  logic [FRAC_BITS-1:0]   frac;

  logic                   accept;
  logic [31:0]            cfg_wide;
  logic [31:0]            len_wide;
  logic [PW-1:0]          d_in, d_hi, d_lo, d_min, d_clamp;
  logic [QW-1:0]          pos_wp, len_fx, dly_q, pos_sub;
  logic [LW-1:0]          c, c_m1, c_p1, c_p2, wp_inc;
  entry_t                 entry;

  assign accept  = start && (state == F_IDLE);
  assign busy    = (state != F_IDLE);
  assign q_push  = (state == F_PUSH) && !q_full;
  assign q_wdata = entry;

  // Length clamp on a register write
  assign cfg_wide = 32'(cfg_data);
  always_comb begin
    if (cfg_wide < 32'd2) begin
      len_wide = 32'd2;
    end else if (cfg_wide > 32'(MAX_DEPTH)) begin
      len_wide = 32'(MAX_DEPTH);
    end else begin
      len_wide = cfg_wide;
    end
  end

  // Delay clamp to [1, len-2] in fixed point; shortest line gives 1
  always_comb begin
    d_in    = PW'(delay_amount);
    d_hi    = PW'(len - LW'(2)) << FRAC_BITS;
    d_lo    = PW'(1) << FRAC_BITS;
    d_min   = (d_in > d_hi) ? d_hi : d_in;
    d_clamp = (d_min < d_lo) ? d_lo : d_min;
  end

  // Read position, stepped back from the write pointer with wrap
  always_comb begin
    pos_wp  = QW'(wp) << FRAC_BITS;
    len_fx  = QW'(len) << FRAC_BITS;
    dly_q   = QW'(dly);
    pos_sub = (pos_wp < dly_q) ? pos_wp + len_fx - dly_q : pos_wp - dly_q;
  end

  // Tap addresses around the centre, each wrapped at len
  always_comb begin
    c      = LW'(centre);
    c_m1   = (c == '0) ? len - LW'(1) : c - LW'(1);
    c_p1   = (c + LW'(1) == len) ? '0 : c + LW'(1);
    c_p2   = (c + LW'(2) >= len) ? c + LW'(2) - len : c + LW'(2);
    wp_inc = LW'(wp) + LW'(1);
  end

  always_comb begin
    entry      = '0;
    entry.cmd  = cur_cmd;
    entry.data = cur_data;
    if (cur_cmd == CMD_WRITE) begin
      for (int i = 0; i < 4; i++) begin
        entry.idx[i] = wp;
      end
      entry.vld = '1;
    end else begin
      entry.frac   = frac;
      entry.idx[0] = c_m1[AW-1:0];
      entry.idx[1] = c[AW-1:0];
      entry.idx[2] = c_p1[AW-1:0];
      entry.idx[3] = c_p2[AW-1:0];
      // entries not yet written since the last clear read as zero
      for (int i = 0; i < 4; i++) begin
        entry.vld[i] = wrapped || (entry.idx[i] < wp);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = (cmd == CMD_READ) ? F_POS : F_PUSH;
        end
      end
      F_POS: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      len     <= LW'(LEN_RST);
      wp      <= '0;
      wrapped <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        len     <= LW'(len_wide);
        wp      <= '0;
        wrapped <= 1'b0;
      end else if (q_push && (cur_cmd == CMD_WRITE)) begin
        if (wp_inc == len) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd  <= cmd_t'(cmd);
      cur_data <= sample_in;
      dly      <= d_clamp[DW-1:0];
    end
    if (state == F_POS) begin
      centre <= pos_sub[FRAC_BITS +: AW];
      frac   <= pos_sub[FRAC_BITS-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("front not busy after accepting a transaction");
  a_pos_is_read: assert property (@(posedge clk) disable iff (rst)
    (state == F_POS) |-> (cur_cmd == CMD_READ))
    else $error("position stage entered for a write");
  a_wp_in_range: assert property (@(posedge clk) disable iff (rst) LW'(wp) < len)
    else $error("write pointer beyond line length");
`endif

endmodule

/* src/cfdl_back.sv */
// cfdl_back: sample store, tap reads and Catmull-Rom evaluation with one shared multiplier.
// Depends on cfdl_pkg.
module cfdl_back import cfdl_pkg::*; #(
  parameter int MAX_DEPTH   = 32768,
  parameter int FRAC_BITS   = 12,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = $clog2(MAX_DEPTH),
  localparam int EW = 1 + SAMPLE_BITS + FRAC_BITS + 4 * AW + 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [EW-1:0]          q_rdata,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] sample_out
);

  localparam int CW  = SAMPLE_BITS + 5;
  localparam int PRW = CW + FRAC_BITS + 1;
  localparam logic signed [CW-1:0]  SMAX =
    signed'({{(CW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [CW-1:0]  SMIN = ~SMAX;
  localparam logic signed [PRW-1:0] RND_HALF = signed'(PRW'(1) << (FRAC_BITS - 1));
  localparam logic signed [PRW-1:0] RND_ONE  = signed'(PRW'(1) << FRAC_BITS);

  typedef struct packed {
    cmd_t                       cmd;
    logic [SAMPLE_BITS-1:0]     data;
    logic [FRAC_BITS-1:0]       frac;
    logic [3:0][AW-1:0]         idx;
    logic [3:0]                 vld;
  } entry_t;

  typedef enum logic [9:0] {
    B_IDLE = 10'b00_0000_0001,
    B_READ = 10'b00_0000_0010,
    B_LAST = 10'b00_0000_0100,
    B_COEF = 10'b00_0000_1000,
    B_M1   = 10'b00_0001_0000,
    B_A1   = 10'b00_0010_0000,
    B_M2   = 10'b00_0100_0000,
    B_A2   = 10'b00_1000_0000,
    B_M3   = 10'b01_0000_0000,
    B_FIN  = 10'b10_0000_0000
  } bstate_t;

  bstate_t state, state_next;

  logic [SAMPLE_BITS-1:0]        mem [MAX_DEPTH];
  logic [SAMPLE_BITS-1:0]        rdata;
  entry_t                        head;
  entry_t                        cur;
  logic [1:0]                    rd_cnt;
  logic                          cap_en;
  logic                          cap_vld;
  logic                          mem_we;
  logic signed [SAMPLE_BITS-1:0] y [4];
  logic signed [CW-1:0]          ye [4];
  logic signed [CW-1:0]          a0, a1, a2, v;
  logic signed [PRW-1:0]         prod;
  logic signed [CW-1:0]          mul_a;
  logic signed [FRAC_BITS:0]     mul_t;
  logic signed [CW-1:0]          acc_add;
  logic signed [PRW-1:0]         rnd_h, sh_h, rnd_f, sh_f;
  logic signed [CW-1:0]          res, res_sat;

  assign head   = q_rdata;
  assign q_pop  = (state == B_IDLE) && !q_empty;
  assign mem_we = q_pop && (head.cmd == CMD_WRITE);

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.idx[1]] <= head.data;
    end
    rdata <= mem[cur.idx[rd_cnt]];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ye[i] = CW'(y[i]);
    end
  end

  // Shared multiplier, fraction taken as a non-negative signed operand
  assign mul_a   = (state == B_M1) ? a0 : v;
  assign mul_t   = signed'({1'b0, cur.frac});
  assign acc_add = (state == B_A1) ? a1 : a2;

  // Rounding steps add a half and then floor with an arithmetic shift
  always_comb begin
    rnd_h = prod + RND_HALF;
    sh_h  = rnd_h >>> FRAC_BITS;
    rnd_f = prod + RND_ONE;
    sh_f  = rnd_f >>> (FRAC_BITS + 1);
    res   = ye[1] + signed'(sh_f[CW-1:0]);
    if (res > SMAX) begin
      res_sat = SMAX;
    end else if (res < SMIN) begin
      res_sat = SMIN;
    end else begin
      res_sat = res;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_pop && (head.cmd == CMD_READ)) begin
          state_next = B_READ;
        end
      end
      B_READ: begin
        if (rd_cnt == 2'd3) begin
          state_next = B_LAST;
        end
      end
      B_LAST:  state_next = B_COEF;
      B_COEF:  state_next = B_M1;
      B_M1:    state_next = B_A1;
      B_A1:    state_next = B_M2;
      B_M2:    state_next = B_A2;
      B_A2:    state_next = B_M3;
      B_M3:    state_next = B_FIN;
      B_FIN:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rd_cnt <= '0;
      cap_en <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      cap_en <= (state == B_READ);
      done   <= (state == B_FIN);
      if (state == B_READ) begin
        rd_cnt <= rd_cnt + 2'd1;
      end else begin
        rd_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    cap_vld <= cur.vld[rd_cnt];
    if (cap_en) begin
      y[0] <= y[1];
      y[1] <= y[2];
      y[2] <= y[3];
      y[3] <= cap_vld ? signed'(rdata) : '0;
    end
    if (state == B_COEF) begin
      a0 <= -ye[0] + (ye[1] <<< 1) + ye[1] - (ye[2] <<< 1) - ye[2] + ye[3];
      a1 <= (ye[0] <<< 1) - (ye[1] <<< 2) - ye[1] + (ye[2] <<< 2) - ye[3];
      a2 <= ye[2] - ye[0];
    end
    if ((state == B_M1) || (state == B_M2) || (state == B_M3)) begin
      prod <= mul_a * mul_t;
    end
    if ((state == B_A1) || (state == B_A2)) begin
      v <= signed'(sh_h[CW-1:0]) + acc_add;
    end
    if (state == B_FIN) begin
      sample_out <= res_sat[SAMPLE_BITS-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_done_from_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == B_FIN))
    else $error("result strobe without a finishing step");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_four_taps: assert property (@(posedge clk) disable iff (rst)
    (state == B_LAST) |-> ($past(rd_cnt) == 2'd3))
    else $error("tap read sequence ended early");
  a_taps_captured: assert property (@(posedge clk) disable iff (rst)
    (state == B_COEF) |-> $past(cap_en))
    else $error("coefficients computed before the last tap was captured");
`endif

endmodule

/* src/cubic_fractional_delay_line.sv */
// cubic_fractional_delay_line: circular delay line with Catmull-Rom cubic read-out.
// A read passes the front (position, push), the queue, then the back before done rises.
// The front takes one transaction at a time and stays busy until it is pushed into the
//   queue, which it waits for while the queue is full. The back retires a write as it
//   pops it and a read by four taps through the one store read port, then three passes
//   through the shared multiplier. A 2-deep queue decouples the two parts.
// Reset (rst, synchronous) and a line_length write empty the line at once: no clearing pass.
module cubic_fractional_delay_line import cfdl_pkg::*; #(
  parameter int MAX_DEPTH   = 32768,
  parameter int FRAC_BITS   = 12,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  // command transaction: taken when start is high and busy is low
  input  logic                   start,
  output logic                   busy,
  input  logic                   cmd,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [DELAY_W-1:0]     delay_amount,
  // result transaction: valid for the single cycle in which done is high
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] sample_out,
  // line_length register
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int AW          = $clog2(MAX_DEPTH);
  localparam int EW          = 1 + SAMPLE_BITS + FRAC_BITS + 4 * AW + 4;
  localparam int QUEUE_DEPTH = 2;

  // Queue entries carry either a store write (address and sample) or a
  // fully resolved read: four tap addresses, their written flags and the fraction.
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [EW-1:0] q_wdata;
  logic [EW-1:0] q_rdata;

  // Front: handshake, length register, write pointer, delay clamp, tap addressing.
  // The write pointer moves here, so reads see every earlier write in queue order.
  cfdl_front #(
    .MAX_DEPTH   (MAX_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .sample_in    (sample_in),
    .delay_amount (delay_amount),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .q_full       (q_full)
  );

  cfdl_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: owns the sample store. Taps never written since the last clear are
  // forced to zero, which stands in for clearing the whole store.
  cfdl_back #(
    .MAX_DEPTH   (MAX_DEPTH),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rdata    (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .done       (done),
    .sample_out (sample_out)
  );

endmodule
